>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk, disabled while rst is high; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CHK_NEVER(lbl, cond, msg)
`define CHK_IMPLY(lbl, ante, cons, msg)
`endif
`endif

>>> src/lfpsa_pkg.sv
// ----------------------------------------------------------------------------
// lfpsa_pkg
// Shared types and constants of the range sensor frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfpsa_pkg;

  localparam int POINTS_DEFAULT = 16;
  localparam int RING_DEFAULT   = 64;

  // distance accumulator wide enough for up to 32 points of 16 bits
  localparam int DIST_W  = 21;
  localparam int WORD_W  = 16;
  localparam int MID_W   = 17;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = 3;

  localparam logic [MID_W:0] FULL_TURN = 18'd36000;
  localparam logic [MID_W:0] TWO_TURNS = 18'd72000;

  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [IDX_W-1:0] REG_LENGTH_BYTE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SECTOR_LOW    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SECTOR_HIGH   = 3'd4;

  localparam logic [7:0]        RST_HEADER_FIRST  = 8'd165;
  localparam logic [7:0]        RST_HEADER_SECOND = 8'd90;
  localparam logic [7:0]        RST_LENGTH_BYTE   = 8'd58;
  localparam logic [WORD_W-1:0] RST_SECTOR_LOW    = 16'd5000;
  localparam logic [WORD_W-1:0] RST_SECTOR_HIGH   = 16'd31000;

  typedef struct packed {
    logic [7:0]        header_first;
    logic [7:0]        header_second;
    logic [7:0]        length_byte;
    logic [WORD_W-1:0] sector_low;
    logic [WORD_W-1:0] sector_high;
  } cfg_t;

  // one parsed frame, handed from the front to the back
  typedef struct packed {
    logic              good;
    logic [WORD_W-1:0] speed;
    logic [WORD_W-1:0] sweep_start;
    logic [WORD_W-1:0] end_angle;
    logic [MID_W-1:0]  mid_angle;
    logic [DIST_W-1:0] dist_total;
  } frame_rec_t;

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] speed;
    logic [WORD_W-1:0] sweep_start;
    logic [WORD_W-1:0] end_angle;
    logic [MID_W-1:0]  mid_angle;
    logic [WORD_W-1:0] mean_distance;
    logic              in_front;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

>>> src/lfpsa_front.sv
// ----------------------------------------------------------------------------
// lfpsa_front
// Byte hunter: checks header, captures words, sums distances and checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfpsa_front #(
  parameter int POINTS_PER_FRAME = lfpsa_pkg::POINTS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lfpsa_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  q_full,
  output logic                  push,
  output lfpsa_pkg::frame_rec_t rec
);
  import lfpsa_pkg::*;

  localparam int PH_END_HI = 7 + 3 * POINTS_PER_FRAME;
  localparam int PH_CHECK  = PH_END_HI + 2;
  localparam int PH_W      = $clog2(PH_CHECK + 1);

  localparam logic [PH_W-1:0] PH_HDR1    = PH_W'(0);
  localparam logic [PH_W-1:0] PH_HDR2    = PH_W'(1);
  localparam logic [PH_W-1:0] PH_LEN     = PH_W'(2);
  localparam logic [PH_W-1:0] PH_SPD_HI  = PH_W'(3);
  localparam logic [PH_W-1:0] PH_SPD_LO  = PH_W'(4);
  localparam logic [PH_W-1:0] PH_STA_HI  = PH_W'(5);
  localparam logic [PH_W-1:0] PH_STA_LO  = PH_W'(6);
  localparam logic [PH_W-1:0] PH_ENDH    = PH_W'(PH_END_HI);
  localparam logic [PH_W-1:0] PH_CHK     = PH_W'(PH_CHECK);

  localparam logic [1:0] K_HIGH     = 2'd0;
  localparam logic [1:0] K_LOW      = 2'd1;
  localparam logic [1:0] K_STRENGTH = 2'd2;

  logic [PH_W-1:0]   phase, phase_next;
  logic [7:0]        run_sum, run_sum_next;
  logic [WORD_W-1:0] speed_word, speed_word_next;
  logic [WORD_W-1:0] start_word, start_word_next;
  logic [WORD_W-1:0] end_word, end_word_next;
  logic [7:0]        hold, hold_next;
  logic [DIST_W-1:0] dist_acc, dist_acc_next;
  logic [1:0]        kpos, kpos_next;
  logic              accept;
  logic [MID_W:0]    end_ext;
  logic [MID_W:0]    mid_sum;
  logic [MID_W:0]    mid_wrap;

  assign in_ready = !((phase == PH_CHK) && q_full);
  assign accept   = in_valid && in_ready;
  assign push     = accept && (phase == PH_CHK);

  // mid angle from the registered words
  always_comb begin
    end_ext  = (start_word > end_word) ? ({2'b00, end_word} + FULL_TURN) : {2'b00, end_word};
    mid_sum  = {2'b00, start_word} + end_ext;
    mid_wrap = (mid_sum >= TWO_TURNS) ? (mid_sum - TWO_TURNS) : mid_sum;
  end

  always_comb begin
    rec.good        = (run_sum == in_byte);
    rec.speed       = speed_word;
    rec.sweep_start = start_word;
    rec.end_angle   = end_word;
    rec.mid_angle   = mid_wrap[MID_W-1:0];
    rec.dist_total  = dist_acc;
  end

  always_comb begin
    phase_next      = phase + PH_W'(1);
    run_sum_next    = run_sum + in_byte;
    speed_word_next = speed_word;
    start_word_next = start_word;
    end_word_next   = end_word;
    hold_next       = hold;
    dist_acc_next   = dist_acc;
    kpos_next       = kpos;
    if (phase == PH_CHK) begin
      phase_next   = PH_HDR1;
      run_sum_next = '0;
    end else if (phase == PH_HDR1) begin
      if (in_byte != cfg.header_first) begin
        phase_next   = PH_HDR1;
        run_sum_next = '0;
      end else begin
        dist_acc_next = '0;
      end
    end else if (phase == PH_HDR2) begin
      if (in_byte != cfg.header_second) begin
        phase_next   = PH_HDR1;
        run_sum_next = '0;
      end
    end else if (phase == PH_LEN) begin
      if (in_byte != cfg.length_byte) begin
        phase_next   = PH_HDR1;
        run_sum_next = '0;
      end
    end else if (phase == PH_SPD_HI) begin
      speed_word_next = {in_byte, speed_word[7:0]};
    end else if (phase == PH_SPD_LO) begin
      speed_word_next = {speed_word[15:8], in_byte};
    end else if (phase == PH_STA_HI) begin
      start_word_next = {in_byte, start_word[7:0]};
    end else if (phase == PH_STA_LO) begin
      start_word_next = {start_word[15:8], in_byte};
      kpos_next       = K_HIGH;
    end else if (phase < PH_ENDH) begin
      case (kpos)
        K_HIGH:  hold_next = in_byte;
        K_LOW:   dist_acc_next = dist_acc + DIST_W'({hold, in_byte});
        default: ;
      endcase
      kpos_next = (kpos == K_STRENGTH) ? K_HIGH : kpos + 2'd1;
    end else if (phase == PH_ENDH) begin
      hold_next = in_byte;
    end else begin
      end_word_next = {hold, in_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR1;
      run_sum    <= '0;
      speed_word <= '0;
      start_word <= '0;
      end_word   <= '0;
      hold       <= '0;
      dist_acc   <= '0;
      kpos       <= K_HIGH;
    end else if (accept) begin
      phase      <= phase_next;
      run_sum    <= run_sum_next;
      speed_word <= speed_word_next;
      start_word <= start_word_next;
      end_word   <= end_word_next;
      hold       <= hold_next;
      dist_acc   <= dist_acc_next;
      kpos       <= kpos_next;
    end
  end

endmodule

>>> src/lfpsa_queue.sv
// ----------------------------------------------------------------------------
// lfpsa_queue
// Two-entry frame queue between the byte front and the result back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfpsa_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lfpsa_pkg::frame_rec_t push_rec,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output lfpsa_pkg::frame_rec_t head
);
  import lfpsa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  frame_rec_t       entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W + 1)'(1);
        2'b01:   count <= count - (PTR_W + 1)'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> src/lfpsa_back.sv
// ----------------------------------------------------------------------------
// lfpsa_back
// Result stages: sector test, ring slot, mean distance, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfpsa_back #(
  parameter int POINTS_PER_FRAME = lfpsa_pkg::POINTS_DEFAULT,
  parameter int RING_DEPTH       = lfpsa_pkg::RING_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lfpsa_pkg::cfg_t       cfg,
  input  logic                  rec_valid,
  input  lfpsa_pkg::frame_rec_t rec,
  output logic                  pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output lfpsa_pkg::result_t    res
);
  import lfpsa_pkg::*;

  // mean = total / points by reciprocal, then one correction step
  localparam int                PROD_W = 2 * DIST_W + 1;
  localparam int                PNT_W  = $clog2(POINTS_PER_FRAME + 1);
  localparam logic [DIST_W:0]   RECIP  = (DIST_W + 1)'((1 << DIST_W) / POINTS_PER_FRAME);
  localparam logic [PNT_W-1:0]  PNT    = PNT_W'(POINTS_PER_FRAME);
  localparam logic [SLOT_W:0]   RING_END = (SLOT_W + 1)'(RING_DEPTH);

  logic              a_valid;
  logic              a_ready;
  logic              a_good;
  logic [WORD_W-1:0] a_speed;
  logic [WORD_W-1:0] a_start;
  logic [WORD_W-1:0] a_end;
  logic [MID_W-1:0]  a_mid;
  logic              a_front;
  logic [SLOT_W-1:0] a_slot;
  logic [DIST_W-1:0] a_dist;
  logic [PROD_W-1:0] a_prod;

  logic [SLOT_W-1:0] ring_index;
  logic [SLOT_W:0]   ring_inc;
  logic              front_c;
  logic [DIST_W-1:0] dist_c;

  logic              b_load;
  logic [WORD_W-1:0] q0;
  logic [WORD_W+PNT_W-1:0] q0_mul;
  logic [DIST_W-1:0] rem;
  logic [WORD_W-1:0] mean_c;

  assign a_ready = !a_valid || b_load;
  assign pop     = rec_valid && a_ready;
  assign b_load  = a_valid && (!res_valid || res_ready);

  always_comb begin
    front_c  = rec.good && ((rec.mid_angle > {cfg.sector_high, 1'b0}) ||
                            (rec.mid_angle < {cfg.sector_low, 1'b0}));
    dist_c   = rec.good ? rec.dist_total : '0;
    ring_inc = {1'b0, ring_index} + (SLOT_W + 1)'(1);
  end

  always_comb begin
    q0     = a_prod[DIST_W +: WORD_W];
    q0_mul = q0 * PNT;
    rem    = a_dist - DIST_W'(q0_mul);
    mean_c = (rem >= DIST_W'(PNT)) ? (q0 + WORD_W'(1)) : q0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      ring_index <= '0;
    end else begin
      if (a_ready) begin
        a_valid <= pop;
      end
      // advance the ring only for good frames in the front sector
      if (pop && front_c) begin
        ring_index <= (ring_inc >= RING_END) ? '0 : ring_inc[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_good  <= rec.good;
      a_speed <= rec.good ? rec.speed : '0;
      a_start <= rec.good ? rec.sweep_start : '0;
      a_end   <= rec.good ? rec.end_angle : '0;
      a_mid   <= rec.good ? rec.mid_angle : '0;
      a_front <= front_c;
      a_slot  <= ring_index;
      a_dist  <= dist_c;
      a_prod  <= PROD_W'(dist_c * RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      res.status        <= !a_good;
      res.speed         <= a_speed;
      res.sweep_start   <= a_start;
      res.end_angle     <= a_end;
      res.mid_angle     <= a_mid;
      res.mean_distance <= mean_c;
      res.in_front      <= a_front;
      res.slot          <= a_slot;
    end
  end

endmodule

>>> src/lidar_frame_parser_sector_average.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser_sector_average
// Frame parser for a scanning range sensor with sector flag and mean distance.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_*      in         tvalid / tready    one received byte
//  m_*      out        tvalid / tready    one result per checksum byte
//  cfg_*    in         valid / ready      register index and write data
//
//  One byte is taken per cycle; only a checksum byte can stall, when the
//  two-entry frame queue is full.
//  A result follows its checksum byte through the queue, the sector and
//  multiply stage, then the correction stage that feeds the output register.
//  Reset is synchronous; no clearing pass is needed. cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lidar_frame_parser_sector_average #(
  parameter int POINTS_PER_FRAME = lfpsa_pkg::POINTS_DEFAULT,
  parameter int RING_DEPTH       = lfpsa_pkg::RING_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,    // rx_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // speed, sweep_start, end_angle, mid_angle, mean_distance, in_front, slot
  output logic [87:0]                 m_tdata,
  output logic                        m_tuser,    // status
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lfpsa_pkg::IDX_W-1:0] cfg_index,
  input  logic [15:0]                 cfg_data
);
  import lfpsa_pkg::*;

  cfg_t       cfg;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_not_empty;
  frame_rec_t push_rec;
  frame_rec_t head_rec;
  result_t    res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= RST_HEADER_FIRST;
      cfg.header_second <= RST_HEADER_SECOND;
      cfg.length_byte   <= RST_LENGTH_BYTE;
      cfg.sector_low    <= RST_SECTOR_LOW;
      cfg.sector_high   <= RST_SECTOR_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  cfg.header_first  <= cfg_data[7:0];
        REG_HEADER_SECOND: cfg.header_second <= cfg_data[7:0];
        REG_LENGTH_BYTE:   cfg.length_byte   <= cfg_data[7:0];
        REG_SECTOR_LOW:    cfg.sector_low    <= cfg_data;
        REG_SECTOR_HIGH:   cfg.sector_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  lfpsa_front #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_byte (s_tdata),
    .q_full  (q_full),
    .push    (q_push),
    .rec     (push_rec)
  );

  lfpsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (head_rec)
  );

  lfpsa_back #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME),
    .RING_DEPTH      (RING_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rec_valid(q_not_empty),
    .rec      (head_rec),
    .pop      (q_pop),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  assign m_tuser = res.status;
  assign m_tdata = {res.slot, res.in_front, res.mean_distance, res.mid_angle,
                    res.end_angle, res.sweep_start, res.speed};

  `CHK_NEVER(a_queue_overflow, q_push && q_full && !q_pop, "frame queue overflow")
  `CHK_IMPLY(a_bad_zero, m_tvalid && m_tuser, m_tdata[81:0] == '0, "bad frame fields not zero")
  `CHK_IMPLY(a_slot_range, m_tvalid, m_tdata[87:82] <= SLOT_W'(RING_DEPTH - 1), "slot beyond ring")

endmodule
